[src/mtfo_pkg.sv]
// Shared types, constants, microcode table and word functions of the first-outputs generator.
package mtfo_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 7;
	localparam int IDX_W   = 10;

	localparam logic [WORD_W-1:0] MT_MULT     = 32'h6c07_8965;
	localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hefc6_0000;
	localparam logic [IDX_W-1:0]  MT_SHIFT    = 10'd397;

	// microcode addresses
	typedef enum logic [2:0] {
		UPC_IDLE,
		UPC_HEAD,
		UPC_CHAIN,
		UPC_FAR,
		UPC_PRIME,
		UPC_FETCH,
		UPC_EMIT
	} upc_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_CNT_ZERO,
		COND_IDX_EQ_N,
		COND_IDX_EQ_SHIFT,
		COND_K_EQ_N,
		COND_LAST
	} cond_t;

	// adv and inc_k act when the jump is not taken, clr_k when it is
	typedef struct packed {
		logic  wait_in;
		logic  wait_out;
		logic  load;
		logic  wr_head;
		logic  wr_far;
		logic  rd;
		logic  rd_ahead;
		logic  cap_hk;
		logic  emit;
		logic  adv;
		logic  inc_k;
		logic  clr_k;
		cond_t cond;
		upc_t  target;
		upc_t  fall;
	} ucode_t;

	function automatic ucode_t ucode(upc_t pc);
		ucode_t uc;
		uc = '0;
		case (pc)
			UPC_IDLE: begin
				uc.wait_in = 1'b1;
				uc.load    = 1'b1;
				uc.cond    = COND_CNT_ZERO;
				uc.target  = UPC_IDLE;
				uc.fall    = UPC_HEAD;
			end
			UPC_HEAD: begin
				uc.wr_head = 1'b1;
				uc.adv     = 1'b1;
				uc.cond    = COND_IDX_EQ_N;
				uc.target  = UPC_CHAIN;
				uc.fall    = UPC_HEAD;
			end
			UPC_CHAIN: begin
				uc.adv    = 1'b1;
				uc.clr_k  = 1'b1;
				uc.cond   = COND_IDX_EQ_SHIFT;
				uc.target = UPC_FAR;
				uc.fall   = UPC_CHAIN;
			end
			UPC_FAR: begin
				uc.wr_far = 1'b1;
				uc.adv    = 1'b1;
				uc.inc_k  = 1'b1;
				uc.clr_k  = 1'b1;
				uc.cond   = COND_K_EQ_N;
				uc.target = UPC_PRIME;
				uc.fall   = UPC_FAR;
			end
			UPC_PRIME: begin
				uc.rd     = 1'b1;
				uc.cond   = COND_ALWAYS;
				uc.target = UPC_FETCH;
				uc.fall   = UPC_FETCH;
			end
			UPC_FETCH: begin
				uc.rd       = 1'b1;
				uc.rd_ahead = 1'b1;
				uc.cap_hk   = 1'b1;
				uc.cond     = COND_ALWAYS;
				uc.target   = UPC_EMIT;
				uc.fall     = UPC_EMIT;
			end
			UPC_EMIT: begin
				uc.wait_out = 1'b1;
				uc.emit     = 1'b1;
				uc.inc_k    = 1'b1;
				uc.cond     = COND_LAST;
				uc.target   = UPC_IDLE;
				uc.fall     = UPC_FETCH;
			end
			default: begin
				uc.cond   = COND_ALWAYS;
				uc.target = UPC_IDLE;
				uc.fall   = UPC_IDLE;
			end
		endcase
		return uc;
	endfunction

	function automatic logic [WORD_W-1:0] next_init(logic [WORD_W-1:0] prev,
			logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] t;
		t = prev ^ (prev >> 30);
		return MT_MULT * t + {{(WORD_W-IDX_W){1'b0}}, idx};
	endfunction

	function automatic logic [WORD_W-1:0] twist(logic [WORD_W-1:0] hi,
			logic [WORD_W-1:0] lo, logic [WORD_W-1:0] far);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] w;
		y = (hi & MT_UPPER) | (lo & MT_LOWER);
		w = (y >> 1) ^ far;
		if (y[0]) begin
			w = w ^ MT_MATRIX;
		end
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] temper(logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[src/mt19937_first_outputs.sv]
// Top level: leading tempered outputs of a 32-bit Mersenne Twister, microcoded.
//
//  channel  | dir | fields (low bit up)                      | handshake
//  s_axis   | in  | tdata: seed[31:0], count[38:32], pad[39] | tvalid/tready
//  m_axis   | out | tdata: value[31:0]; tlast: last          | tvalid/tready
//
// One request with count n (1..MAX_COUNT) fills the head and far words, then emits n outputs;
// a count of zero is taken in the idle step and gives nothing.
// The single multiply-add unit builds one chained state word per cycle, and each
// output then needs a RAM read step and an emit step.
// Reset clears the sequencer and the output valid flag; the word RAMs need no clearing.
// A stalled output holds the emit step; new requests are taken only in the idle step.
module mt19937_first_outputs
	import mtfo_pkg::*;
#(
	parameter int MAX_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // seed[31:0], count[38:32], zero pad[39]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value[31:0]
	output logic        m_axis_tlast
);

	localparam int DEPTH = MAX_COUNT + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	upc_t              pc_q, pc_d;
	ucode_t            uc;
	logic              go, jump;
	logic [WORD_W-1:0] w_q, hk_q, value_q;
	logic [IDX_W-1:0]  idx_q, idx_inc;
	logic [AW-1:0]     k_q, n_q, k1, n_sat, head_rd_addr;
	logic              out_valid_q, last_q;
	logic [WORD_W-1:0] head_rdata, far_rdata, seed_in;
	logic [COUNT_W-1:0] count_in;

	assign seed_in  = s_axis_tdata[31:0];
	assign count_in = s_axis_tdata[38:32];
	assign idx_inc  = idx_q + IDX_W'(1);
	assign k1       = k_q + AW'(1);
	assign n_sat    = (int'(count_in) > MAX_COUNT) ? AW'(MAX_COUNT) : AW'(count_in);

	// decode the current step and its branch condition
	always_comb begin
		uc = ucode(pc_q);
		go = !(uc.wait_in && !s_axis_tvalid) &&
			!(uc.wait_out && out_valid_q && !m_axis_tready);
		case (uc.cond)
			COND_ALWAYS:       jump = 1'b1;
			COND_CNT_ZERO:     jump = (count_in == '0);
			COND_IDX_EQ_N:     jump = (idx_q == IDX_W'(n_q));
			COND_IDX_EQ_SHIFT: jump = (idx_q == MT_SHIFT);
			COND_K_EQ_N:       jump = (k_q == n_q);
			COND_LAST:         jump = (k1 == n_q);
			default:           jump = 1'b1;
		endcase
	end

	always_comb begin
		pc_d = pc_q;
		if (go) begin
			pc_d = jump ? uc.target : uc.fall;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= UPC_IDLE;
			idx_q <= '0;
			k_q   <= '0;
		end else begin
			pc_q <= pc_d;
			if (go) begin
				if (uc.load) begin
					idx_q <= '0;
					k_q   <= '0;
				end else begin
					if (uc.adv && !jump) begin
						idx_q <= idx_inc;
					end
					if (uc.inc_k && !jump) begin
						k_q <= k1;
					end else if (uc.clr_k && jump) begin
						k_q <= '0;
					end
				end
			end
		end
	end

	// chained word and captured head word
	always_ff @(posedge clk) begin
		if (go) begin
			if (uc.load) begin
				w_q <= seed_in;
				n_q <= n_sat;
			end else if (uc.adv && !jump) begin
				w_q <= next_init(w_q, idx_inc);
			end
			if (uc.cap_hk) begin
				hk_q <= head_rdata;
			end
		end
	end

	assign head_rd_addr = uc.rd_ahead ? k1 : k_q;

	mtfo_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_head_ram (
		.clk     (clk),
		.wr_en   (go && uc.wr_head),
		.wr_addr (idx_q[AW-1:0]),
		.wr_data (w_q),
		.rd_en   (go && uc.rd),
		.rd_addr (head_rd_addr),
		.rd_data (head_rdata)
	);

	mtfo_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_far_ram (
		.clk     (clk),
		.wr_en   (go && uc.wr_far),
		.wr_addr (k_q),
		.wr_data (w_q),
		.rd_en   (go && uc.rd),
		.rd_addr (k_q),
		.rd_data (far_rdata)
	);

	// output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && uc.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && uc.emit) begin
			value_q <= temper(twist(hk_q, head_rdata, far_rdata));
			last_q  <= jump;
		end
	end

	assign s_axis_tready = (pc_q == UPC_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tlast  = last_q;

	a_start_head: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (count_in != '0) |=> pc_q == UPC_HEAD)
		else $error("non-empty request did not start the head fill");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q != UPC_IDLE |-> k_q <= n_q)
		else $error("word index ran past the count");

	a_chain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == UPC_CHAIN |-> idx_q <= MT_SHIFT)
		else $error("chain ran past the far offset");

endmodule

[src/mtfo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mtfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
